/* rtl/jse_pkg.sv */
// shared types, character codes and helpers for the json string escaper
package jse_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6e;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam logic [7:0] CTRL_BS = 8'h08;
  localparam logic [7:0] CTRL_HT = 8'h09;
  localparam logic [7:0] CTRL_LF = 8'h0a;
  localparam logic [7:0] CTRL_FF = 8'h0c;
  localparam logic [7:0] CTRL_CR = 8'h0d;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [1:0] {
    BODY_CLOSE,
    BODY_PLAIN,
    BODY_ESC,
    BODY_UNI
  } body_t;

  // one classified input item, waiting to be expanded into bytes
  typedef struct packed {
    logic       open_quote;
    body_t      body;
    logic [7:0] payload;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = CH_ZERO + {4'd0, nib};
    end else begin
      res = 8'h61 + {4'd0, nib} - 8'd10;
    end
    return res;
  endfunction

endpackage

/* rtl/jse_channels.sv */
// valid/ready channel interfaces for characters in and escaped text out
interface jse_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_byte;

  modport source (output valid, output kind, output char_byte, input ready);
  modport sink (input valid, input kind, input char_byte, output ready);
endinterface

interface jse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       closes_string;

  modport source (output valid, output out_byte, output last_of_run,
                  output closes_string, input ready);
  modport sink (input valid, input out_byte, input last_of_run,
                input closes_string, output ready);
endinterface

/* rtl/jse_front.sv */
// front end: accepts input items, tracks the open string and classifies bytes
module jse_front (
  input  logic                 clk,
  input  logic                 rst,
  jse_in_if.sink               chars,
  input  jse_pkg::queue_stat_t stat,
  output logic                 push,
  output jse_pkg::job_t        job
);

  logic inside_string;

  assign chars.ready = !stat.full;
  assign push        = chars.valid && chars.ready;

  always_comb begin
    job.open_quote = !inside_string;
    job.body       = jse_pkg::BODY_PLAIN;
    job.payload    = chars.char_byte;
    if (chars.kind == jse_pkg::KIND_END) begin
      job.body    = jse_pkg::BODY_CLOSE;
      job.payload = jse_pkg::CH_QUOTE;
    end else begin
      unique case (chars.char_byte)
        jse_pkg::CH_QUOTE, jse_pkg::CH_BACKSLASH: begin
          job.body = jse_pkg::BODY_ESC;
        end
        jse_pkg::CTRL_BS: begin
          job.body    = jse_pkg::BODY_ESC;
          job.payload = jse_pkg::CH_B;
        end
        jse_pkg::CTRL_FF: begin
          job.body    = jse_pkg::BODY_ESC;
          job.payload = jse_pkg::CH_F;
        end
        jse_pkg::CTRL_LF: begin
          job.body    = jse_pkg::BODY_ESC;
          job.payload = jse_pkg::CH_N;
        end
        jse_pkg::CTRL_CR: begin
          job.body    = jse_pkg::BODY_ESC;
          job.payload = jse_pkg::CH_R;
        end
        jse_pkg::CTRL_HT: begin
          job.body    = jse_pkg::BODY_ESC;
          job.payload = jse_pkg::CH_T;
        end
        default: begin
          if (chars.char_byte < jse_pkg::CH_SPACE) begin
            job.body = jse_pkg::BODY_UNI;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_string <= 1'b0;
    end else if (push) begin
      inside_string <= (chars.kind == jse_pkg::KIND_CHAR);
    end
  end

endmodule

/* rtl/jse_queue.sv */
// small register queue of classified jobs between front and back end
module jse_queue #(
  parameter int Depth = jse_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  jse_pkg::job_t        wr_job,
  input  logic                 pop,
  output jse_pkg::job_t        rd_job,
  output jse_pkg::queue_stat_t stat
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(Depth - 1);

  jse_pkg::job_t slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign rd_job     = slots[rd_ptr];
  assign stat.full  = (count == CntW'(Depth));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastSlot) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastSlot) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/jse_back.sv */
// back end: expands the job at the queue head into output bytes, one per cycle while the output is ready
module jse_back (
  input  logic                 clk,
  input  logic                 rst,
  input  jse_pkg::job_t        job,
  input  jse_pkg::queue_stat_t stat,
  output logic                 pop,
  jse_out_if.source            text
);

  logic [2:0] step;
  logic [2:0] body_len;
  logic [2:0] total;
  logic [2:0] body_idx;
  logic       is_last;
  logic       load;
  logic [7:0] next_byte;
  logic       valid_q;

  always_comb begin
    case (job.body)
      jse_pkg::BODY_ESC: body_len = 3'd2;
      jse_pkg::BODY_UNI: body_len = 3'd6;
      default:           body_len = 3'd1;
    endcase
  end

  assign total    = body_len + {2'd0, job.open_quote};
  assign is_last  = (step == total - 3'd1);
  assign body_idx = step - {2'd0, job.open_quote};

  always_comb begin
    next_byte = job.payload;
    if (job.open_quote && step == 3'd0) begin
      next_byte = jse_pkg::CH_QUOTE;
    end else begin
      unique case (job.body)
        jse_pkg::BODY_CLOSE: next_byte = jse_pkg::CH_QUOTE;
        jse_pkg::BODY_PLAIN: next_byte = job.payload;
        jse_pkg::BODY_ESC: begin
          next_byte = (body_idx == 3'd0) ? jse_pkg::CH_BACKSLASH : job.payload;
        end
        jse_pkg::BODY_UNI: begin
          case (body_idx)
            3'd0:       next_byte = jse_pkg::CH_BACKSLASH;
            3'd1:       next_byte = jse_pkg::CH_U;
            3'd2, 3'd3: next_byte = jse_pkg::CH_ZERO;
            3'd4:       next_byte = jse_pkg::hex_char(job.payload[7:4]);
            default:    next_byte = jse_pkg::hex_char(job.payload[3:0]);
          endcase
        end
        default: next_byte = job.payload;
      endcase
    end
  end

  // output register frees as soon as its transaction completes
  assign load       = !stat.empty && (!valid_q || text.ready);
  assign pop        = load && is_last;
  assign text.valid = valid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
      step    <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        step    <= is_last ? 3'd0 : step + 3'd1;
      end else if (text.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      text.out_byte      <= next_byte;
      text.last_of_run   <= is_last;
      text.closes_string <= is_last && (job.body == jse_pkg::BODY_CLOSE);
    end
  end

endmodule

/* rtl/json_string_escaper_unit.sv */
// Streams string bytes in and emits their JSON-quoted, escaped text one byte per
// transaction. Each output cycle carries one byte from a single output register, so a
// plain character sustains one input item per cycle while the output is ready; an
// opening quote adds one byte, a short escape takes two bytes and a \u00xx escape
// six. A queue of QUEUE_DEPTH classified items lets the input side keep running
// while an escape drains. No clearing pass after reset is needed.
module json_string_escaper_unit #(
  parameter int QueueDepth = jse_pkg::QUEUE_DEPTH
) (
  input logic       clk,
  input logic       rst,
  jse_in_if.sink    chars,
  jse_out_if.source text
);

  jse_pkg::job_t        push_job;
  jse_pkg::job_t        head_job;
  jse_pkg::queue_stat_t q_stat;
  logic                 push;
  logic                 pop;

  jse_front u_front (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .stat  (q_stat),
    .push  (push),
    .job   (push_job)
  );

  jse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (push_job),
    .pop    (pop),
    .rd_job (head_job),
    .stat   (q_stat)
  );

  jse_back u_back (
    .clk  (clk),
    .rst  (rst),
    .job  (head_job),
    .stat (q_stat),
    .pop  (pop),
    .text (text)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !push)
    else $error("push into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_stat.empty |-> !pop)
    else $error("pop from empty queue");

  a_close_is_quote: assert property (@(posedge clk) disable iff (rst)
    text.valid && text.closes_string |-> text.last_of_run
      && text.out_byte == jse_pkg::CH_QUOTE)
    else $error("closing byte is not a final quote");

  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !text.valid)
    else $error("output valid right after reset");

endmodule
